// ----- rtl/sorted_unique_key_table_defines.svh -----
// Assertion helpers used by the top-level table file to check the table logic.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUKT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SUKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sukt_pkg.sv -----
`timescale 1ns / 1ps

package sukt_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_LIST
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_DELETE,
        ACT_UPDATE
    } act_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_UPDATE,
        SEL_FOUND,
        SEL_LIST
    } sel_t;

    typedef struct packed {
        logic       load;
        act_t       act;
        logic       emit;
        logic [2:0] status;
        sel_t       sel;
        logic       last;
        logic       list_next;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       found;
        logic       full;
        logic       empty;
        logic       list_last;
        logic       out_free;
    } stat_t;

endpackage

// ----- rtl/sukt_controller.sv -----
`timescale 1ns / 1ps

module sukt_controller
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [2:0]     in_op,
    output logic           in_ready,
    input  sukt_pkg::stat_t stat,
    output sukt_pkg::cmd_t  cmd
);
    import sukt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.act       = ACT_NONE;
        cmd.emit      = 1'b0;
        cmd.status    = ST_OK;
        cmd.sel       = SEL_ZERO;
        cmd.last      = 1'b1;
        cmd.list_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_op <= OP_LIST)
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_APPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    case (stat.op)
                        OP_INSERT:
                        begin
                            if (stat.found)
                            begin
                                cmd.status = ST_DUP;
                            end
                            else if (stat.full)
                            begin
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.act = ACT_INSERT;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = ST_EMPTY;
                            end
                            else if (!stat.found)
                            begin
                                cmd.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                cmd.act = ACT_DELETE;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (stat.found)
                            begin
                                cmd.sel = SEL_FOUND;
                            end
                            else
                            begin
                                cmd.status = ST_NOTFOUND;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (stat.found)
                            begin
                                cmd.act = ACT_UPDATE;
                                cmd.sel = SEL_UPDATE;
                            end
                            else
                            begin
                                cmd.status = ST_NOTFOUND;
                            end
                        end
                        OP_LIST:
                        begin
                            if (stat.empty)
                            begin
                                cmd.status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.sel       = SEL_LIST;
                                cmd.last      = stat.list_last;
                                cmd.list_next = 1'b1;
                                if (!stat.list_last)
                                begin
                                    state_next = S_LIST;
                                end
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sel       = SEL_LIST;
                    cmd.last      = stat.list_last;
                    cmd.list_next = 1'b1;
                    if (stat.list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sukt_datapath.sv -----
`timescale 1ns / 1ps

module sukt_datapath #(
    parameter int CAPACITY = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      in_op,
    input  logic [15:0]     in_key,
    input  logic [31:0]     in_payload,
    input  sukt_pkg::cmd_t  cmd,
    output sukt_pkg::stat_t stat,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      out_status,
    output logic [15:0]     out_key,
    output logic [31:0]     out_payload,
    output logic [5:0]      out_count,
    output logic            out_last
);
    import sukt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [15:0]         key_cell_reg [CAPACITY];
    logic [31:0]         pay_cell_reg [CAPACITY];
    logic [15:0]         key_cell_next [CAPACITY];
    logic [31:0]         pay_cell_next [CAPACITY];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [IW-1:0]       idx_reg;
    logic [2:0]          op_reg;
    logic [15:0]         key_reg;
    logic [31:0]         payload_reg;
    logic [CAPACITY-1:0] less_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] less_in;
    logic [CAPACITY-1:0] match_in;
    logic [31:0]         found_payload;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [2:0]          out_status_reg;
    logic [15:0]         out_key_reg;
    logic [31:0]         out_payload_reg;
    logic [5:0]          out_count_reg;
    logic                out_last_reg;

    // Every occupied cell compares itself against the incoming key.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            less_in[i]  = (CW'(i) < count_reg) && (key_cell_reg[i] < in_key);
            match_in[i] = (CW'(i) < count_reg) && (key_cell_reg[i] == in_key);
        end
    end

    always_comb
    begin
        found_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found_payload = found_payload | (match_reg[i] ? pay_cell_reg[i] : 32'd0);
        end
    end

    always_comb
    begin
        stat.op        = op_reg;
        stat.found     = |match_reg;
        stat.full      = (count_reg == CW'(CAPACITY));
        stat.empty     = (count_reg == '0);
        stat.list_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        case (cmd.act)
            ACT_INSERT: count_next = count_reg + CW'(1);
            ACT_DELETE: count_next = count_reg - CW'(1);
            default:    count_next = count_reg;
        endcase
    end

    // The sorted cells form a chain. Cells at or above the insertion point
    // move up one place and cells above a deleted record move down over it.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_cell_next[i] = key_cell_reg[i];
            pay_cell_next[i] = pay_cell_reg[i];
        end
        case (cmd.act)
            ACT_INSERT:
            begin
                if (!less_reg[0])
                begin
                    key_cell_next[0] = key_reg;
                    pay_cell_next[0] = payload_reg;
                end
                for (int i = 1; i < CAPACITY; i++)
                begin
                    if (!less_reg[i])
                    begin
                        if (!less_reg[i-1])
                        begin
                            key_cell_next[i] = key_cell_reg[i-1];
                            pay_cell_next[i] = pay_cell_reg[i-1];
                        end
                        else
                        begin
                            key_cell_next[i] = key_reg;
                            pay_cell_next[i] = payload_reg;
                        end
                    end
                end
            end
            ACT_DELETE:
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    if (!less_reg[i])
                    begin
                        key_cell_next[i] = key_cell_reg[i+1];
                        pay_cell_next[i] = pay_cell_reg[i+1];
                    end
                end
            end
            ACT_UPDATE:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (match_reg[i])
                    begin
                        pay_cell_next[i] = payload_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            key_cell_reg[i] <= key_cell_next[i];
            pay_cell_reg[i] <= pay_cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_op;
            key_reg     <= in_key;
            payload_reg <= in_payload;
            less_reg    <= less_in;
            match_reg   <= match_in;
            idx_reg     <= '0;
        end
        else if (cmd.list_next)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.status;
            out_count_reg  <= 6'(count_next);
            out_last_reg   <= cmd.last;
            case (cmd.sel)
                SEL_UPDATE:
                begin
                    out_key_reg     <= key_reg;
                    out_payload_reg <= payload_reg;
                end
                SEL_FOUND:
                begin
                    out_key_reg     <= key_reg;
                    out_payload_reg <= found_payload;
                end
                SEL_LIST:
                begin
                    out_key_reg     <= key_cell_reg[idx_reg];
                    out_payload_reg <= pay_cell_reg[idx_reg];
                end
                default:
                begin
                    out_key_reg     <= '0;
                    out_payload_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign out_count   = out_count_reg;
    assign out_last    = out_last_reg;

endmodule

// ----- rtl/sorted_unique_key_table.sv -----
`timescale 1ns / 1ps
// Sorted table of up to CAPACITY records, each a unique 16-bit key with a 32-bit payload.
// Operations enter on the s_axis channel: tuser carries the operation code and tdata
// carries the key and payload. Results leave on the m_axis channel with the status in
// tuser, the record and the entry count in tdata, and tlast on the final result of an item.
// Insert, delete, lookup and update give one result. A listing gives one result per
// stored record in key order, or one empty-table result. Unused operation codes give none.
// An item is accepted while the block is idle, and its key is compared against all cells
// in that same cycle. The comparison is registered; the shift of the cell chain and the
// result follow in the apply state, which waits until the output register is free.
// A listing then steps through the stored records in key order, one result per record.
// The block holds one item at a time; input ready is high only while it is idle.
// When the receiver stalls, the result waits in the output register and the block
// holds the next result, and any cell update, until that register is free.
// Reset empties the table and clears any pending result; no clearing pass is needed.

`include "sorted_unique_key_table_defines.svh"

module sorted_unique_key_table #(
    parameter int CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key[15:0], payload[47:16]
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_key[15:0], out_payload[47:16], entry_count[53:48]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast
);
    import sukt_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic [15:0] out_key;
    logic [31:0] out_payload;
    logic [5:0]  out_count;

    sukt_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sukt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_op       (s_axis_tuser),
        .in_key      (s_axis_tdata[15:0]),
        .in_payload  (s_axis_tdata[47:16]),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (m_axis_tuser),
        .out_key     (out_key),
        .out_payload (out_payload),
        .out_count   (out_count),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_count, out_payload, out_key};

    `SUKT_ASSERT_SAME(a_emit_free, cmd.emit, stat.out_free, "Result written over a pending result.")
    `SUKT_ASSERT_SAME(a_act_emits, cmd.act != ACT_NONE, cmd.emit, "Table changed without a result.")
    `SUKT_ASSERT_NEXT(a_busy_after_op, s_axis_tvalid && s_axis_tready && s_axis_tuser <= OP_LIST, !s_axis_tready, "Input taken while an item is in work.")
    `SUKT_ASSERT_SAME(a_error_clean, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tlast && m_axis_tdata[47:0] == 48'd0, "Error result carries record data.")

endmodule

// ----- test/sorted_unique_key_table_checker.sv -----
`timescale 1ns / 1ps

module sorted_unique_key_table_checker #(
    parameter int CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key[15:0], payload[47:16]
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // out_key[15:0], out_payload[47:16], entry_count[53:48]
    input  logic [2:0]  m_axis_tuser,   // status[2:0]
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          outstanding
);

    import sukt_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] rec_key;
        logic [31:0] rec_payload;
        logic [5:0]  count;
        logic        fin;
    } table_result_t;

    table_result_t expected_q[$];
    logic [15:0]   key_mem [CAPACITY];
    logic [31:0]   pay_mem [CAPACITY];
    int            fill;
    int            errors;

    function automatic table_result_t make_result(input logic [2:0] st, input logic [15:0] k,
                                                  input logic [31:0] p, input logic fin);
        table_result_t r;
        r.status      = st;
        r.rec_key     = k;
        r.rec_payload = p;
        r.count       = 6'(fill);
        r.fin         = fin;
        return r;
    endfunction

    task automatic predict_operation(input logic [2:0] op, input logic [15:0] k,
                                     input logic [31:0] p);
        int idx;
        int pos;
        idx = -1;
        for (int i = 0; i < fill; i++)
        begin
            if (idx < 0 && key_mem[i] == k)
                idx = i;
        end
        case (op)
            OP_INSERT:
            begin
                if (idx >= 0)
                    expected_q.push_back(make_result(ST_DUP, '0, '0, 1'b1));
                else if (fill >= CAPACITY)
                    expected_q.push_back(make_result(ST_FULL, '0, '0, 1'b1));
                else
                begin
                    pos = 0;
                    while (pos < fill && key_mem[pos] < k)
                        pos++;
                    for (int i = fill; i > pos; i--)
                    begin
                        key_mem[i] = key_mem[i - 1];
                        pay_mem[i] = pay_mem[i - 1];
                    end
                    key_mem[pos] = k;
                    pay_mem[pos] = p;
                    fill++;
                    expected_q.push_back(make_result(ST_OK, '0, '0, 1'b1));
                end
            end
            OP_DELETE:
            begin
                if (fill == 0)
                    expected_q.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
                else if (idx < 0)
                    expected_q.push_back(make_result(ST_NOTFOUND, '0, '0, 1'b1));
                else
                begin
                    for (int i = idx; i + 1 < fill; i++)
                    begin
                        key_mem[i] = key_mem[i + 1];
                        pay_mem[i] = pay_mem[i + 1];
                    end
                    fill--;
                    expected_q.push_back(make_result(ST_OK, '0, '0, 1'b1));
                end
            end
            OP_LOOKUP, OP_UPDATE:
            begin
                if (idx < 0)
                    expected_q.push_back(make_result(ST_NOTFOUND, '0, '0, 1'b1));
                else
                begin
                    if (op == OP_UPDATE)
                        pay_mem[idx] = p;
                    expected_q.push_back(make_result(ST_OK, key_mem[idx], pay_mem[idx], 1'b1));
                end
            end
            OP_LIST:
            begin
                if (fill == 0)
                    expected_q.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
                else
                begin
                    for (int i = 0; i < fill; i++)
                        expected_q.push_back(make_result(ST_OK, key_mem[i], pay_mem[i],
                                                         i == fill - 1));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result();
        table_result_t got;
        table_result_t want;
        got.status      = m_axis_tuser;
        got.rec_key     = m_axis_tdata[15:0];
        got.rec_payload = m_axis_tdata[47:16];
        got.count       = m_axis_tdata[53:48];
        got.fin         = m_axis_tlast;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: status=%0d key=%h payload=%h count=%0d last=%b",
                         got.status, got.rec_key, got.rec_payload, got.count, got.fin);
        end
        else
        begin
            want = expected_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected status=%0d key=%h payload=%h count=%0d last=%b",
                             want.status, want.rec_key, want.rec_payload, want.count, want.fin);
                    $display("          actual   status=%0d key=%h payload=%h count=%0d last=%b",
                             got.status, got.rec_key, got.rec_payload, got.count, got.fin);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            fill        = 0;
            errors      = 0;
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                predict_operation(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]);
            outstanding <= expected_q.size();
            fail_count  <= errors;
        end
    end

endmodule

// ----- test/tb_sorted_unique_key_table.sv -----
`timescale 1ns / 1ps

module tb_sorted_unique_key_table;

    import sukt_pkg::*;

    // Operation codes that the block ignores.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam int POOL_SIZE = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // key[15:0], payload[47:16]
    logic [2:0]  s_axis_tuser = '0;     // op[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // out_key[15:0], out_payload[47:16], entry_count[53:48]
    logic [2:0]  m_axis_tuser;          // status[2:0]
    logic        m_axis_tlast;

    int          fail_count;
    int          outstanding;
    logic [15:0] key_pool [POOL_SIZE];
    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    int          rx_hold = 0;

    always #5 clk = ~clk;

    sorted_unique_key_table #(
        .CAPACITY(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    sorted_unique_key_table_checker #(
        .CAPACITY(32)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    always @(posedge clk)
    begin
        if (rx_steady)
        begin
            m_axis_tready <= 1'b1;
            rx_hold       <= 0;
        end
        else if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold       <= pick_gap();
        end
    end

    task automatic push_item(input logic [2:0] op, input logic [15:0] k, input logic [31:0] p);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {p, k};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic mixed_item();
        int          r;
        logic [2:0]  op;
        logic [15:0] k;
        r = $urandom_range(0, 99);
        if (r < 10)
            op = OP_LIST;
        else if (r < 35)
            op = OP_LOOKUP;
        else if (r < 60)
            op = OP_UPDATE;
        else if (r < 72)
            op = OP_INSERT;
        else if (r < 88)
            op = OP_DELETE;
        else
            op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        k = ($urandom_range(0, 4) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, POOL_SIZE - 1)];
        push_item(op, k, $urandom);
    endtask

    // Inserts every pool key, more than the table holds, with other traffic mixed in.
    task automatic fill_phase();
        int start;
        start = $urandom_range(0, POOL_SIZE - 1);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                mixed_item();
            push_item(OP_INSERT, key_pool[(start + i) % POOL_SIZE], $urandom);
        end
    endtask

    task automatic drain_phase(input int n);
        int start;
        start = $urandom_range(0, POOL_SIZE - 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                mixed_item();
            push_item(OP_DELETE, key_pool[(start + i) % POOL_SIZE], $urandom);
        end
    endtask

    task automatic pick_idling();
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        logic fresh;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_item(OP_LIST, 16'h0000, 32'h0000_0000);
        push_item(OP_DELETE, 16'hFFFF, 32'hFFFF_FFFF);
        push_item(OP_LOOKUP, 16'h0000, 32'h0000_0000);
        push_item(OP_UPDATE, 16'h0000, 32'hFFFF_FFFF);
        push_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        push_item(OP_INSERT, 16'h0000, 32'h0000_0000);
        push_item(OP_INSERT, 16'h1234, $urandom);
        push_item(OP_INSERT, 16'hFFFF, 32'h0000_0000);
        push_item(OP_LOOKUP, 16'h0000, $urandom);
        push_item(OP_UPDATE, 16'h1234, 32'hFFFF_FFFF);
        push_item(OP_LOOKUP, 16'h1234, 32'h0000_0000);
        push_item(OP_LOOKUP, 16'h5555, $urandom);
        push_item(OP_DELETE, 16'hAAAA, $urandom);
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            push_item(3'(op), 16'($urandom), $urandom);
        push_item(OP_LIST, 16'h0000, $urandom);
        push_item(OP_DELETE, 16'h0000, $urandom);
        push_item(OP_LIST, 16'hFFFF, $urandom);
        wait_for_results();

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            do
            begin
                key_pool[i] = 16'($urandom);
                fresh = 1'b1;
                for (int j = 0; j < i; j++)
                begin
                    if (key_pool[j] == key_pool[i])
                        fresh = 1'b0;
                end
            end
            while (!fresh);
        end

        pick_idling();
        fill_phase();
        pick_idling();
        repeat (6) mixed_item();
        pick_idling();
        drain_phase(28);
        wait_for_results();

        pick_idling();
        fill_phase();
        pick_idling();
        repeat (6) mixed_item();
        pick_idling();
        drain_phase(POOL_SIZE);
        repeat (4) mixed_item();

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
